// ===== hw/rtl/md5rc_pkg.sv =====
`timescale 1ns / 1ps

package md5rc_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD_WORK = 2'd0;
    localparam logic [1:0] OP_LOAD_MSG  = 2'd1;
    localparam logic [1:0] OP_RUN       = 2'd2;

    localparam int WordWidth  = 32;
    localparam int WorkDepth  = 4;
    localparam int MsgDepth   = 16;
    localparam int RoundCount = 64;
    localparam int QueueDepth = 4;

    localparam int RoundBits  = $clog2(RoundCount);
    localparam int QueueBits  = $clog2(QueueDepth);
    localparam logic [RoundBits-1:0] LastRound = RoundBits'(RoundCount - 1);

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  index;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  word_index;
        logic [31:0] word_value;
        logic        last;
    } t_out_item;

    // Commands that the front end hands to the back end.
    typedef enum logic [1:0] {
        CMD_LOAD_WORK = 2'd0,
        CMD_LOAD_MSG  = 2'd1,
        CMD_RUN       = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [3:0]  index;
        logic [31:0] value;
    } t_cmd;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ROUND = 2'd1,
        ST_EMIT  = 2'd2
    } t_back_state;

    // Message word used by a given round.
    function automatic logic [3:0] msg_sel(input logic [RoundBits-1:0] r);
        logic [3:0] i;
        logic [3:0] v;
        i = r[3:0];
        case (r[5:4])
            2'd0: v = i;
            2'd1: v = 4'(i * 4'd5 + 4'd1);
            2'd2: v = 4'(i * 4'd3 + 4'd5);
            2'd3: v = 4'(i * 4'd7);
            default: v = i;
        endcase
        return v;
    endfunction

    // Left rotation amount of a given round.
    function automatic logic [4:0] shift_amt(input logic [RoundBits-1:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'hA: s = 5'd16;
            4'hB: s = 5'd23;
            4'hC: s = 5'd6;
            4'hD: s = 5'd10;
            4'hE: s = 5'd15;
            4'hF: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Sine-derived additive constant of a given round.
    function automatic logic [31:0] sine_k(input logic [RoundBits-1:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/md5rc_front.sv =====
`timescale 1ns / 1ps

module md5rc_front import md5rc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic keep;

    assign o_in_stall = r_valid & i_q_status.full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_status.full;
    assign o_cmd      = r_cmd;

    // Operation three and working-word loads beyond word D are dropped here.
    always_comb begin
        keep  = 1'b0;
        n_cmd = r_cmd;
        case (i_in_data.operation)
            OP_LOAD_WORK: begin
                keep       = (i_in_data.index[3:2] == 2'b00);
                n_cmd.kind = CMD_LOAD_WORK;
            end
            OP_LOAD_MSG: begin
                keep       = 1'b1;
                n_cmd.kind = CMD_LOAD_MSG;
            end
            OP_RUN: begin
                keep       = 1'b1;
                n_cmd.kind = CMD_RUN;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        n_cmd.index = i_in_data.index;
        n_cmd.value = i_in_data.value;
        n_valid     = (accept & keep) | (r_valid & i_q_status.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/md5rc_queue.sv =====
`timescale 1ns / 1ps

module md5rc_queue import md5rc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_mem [QueueDepth];
    logic [QueueBits-1:0] r_wr_ptr;
    logic [QueueBits-1:0] r_rd_ptr;
    logic [QueueBits:0]   r_count;

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (QueueBits+1)'(QueueDepth));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/md5rc_back.sv =====
`timescale 1ns / 1ps

module md5rc_back import md5rc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [RoundBits-1:0] r_round;
    logic [RoundBits-1:0] n_round;
    logic [1:0]           r_emit;
    logic [1:0]           n_emit;
    logic [31:0]          r_work [WorkDepth];
    logic [31:0]          r_msg  [MsgDepth];
    logic                 load_work;
    logic                 load_msg;
    logic                 do_round;

    logic [31:0] a_w;
    logic [31:0] b_w;
    logic [31:0] c_w;
    logic [31:0] d_w;
    logic [31:0] mix;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [31:0] rot;

    assign a_w = r_work[0];
    assign b_w = r_work[1];
    assign c_w = r_work[2];
    assign d_w = r_work[3];

    // One MD5 round per cycle, applied in place on the working words.
    always_comb begin
        case (r_round[5:4])
            2'd0: mix = (b_w & c_w) | (~b_w & d_w);
            2'd1: mix = (d_w & b_w) | (~d_w & c_w);
            2'd2: mix = b_w ^ c_w ^ d_w;
            2'd3: mix = c_w ^ (b_w | ~d_w);
            default: mix = '0;
        endcase
        sum     = mix + a_w + sine_k(r_round) + r_msg[msg_sel(r_round)];
        rot_dbl = {sum, sum} << shift_amt(r_round);
        rot     = rot_dbl[63:32];
    end

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_emit    = r_emit;
        o_pop     = 1'b0;
        load_work = 1'b0;
        load_msg  = 1'b0;
        do_round  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_LOAD_WORK: load_work = 1'b1;
                        CMD_LOAD_MSG:  load_msg  = 1'b1;
                        CMD_RUN: begin
                            n_state = ST_ROUND;
                            n_round = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                do_round = 1'b1;
                n_round  = r_round + 1'b1;
                if (r_round == LastRound) begin
                    n_state = ST_EMIT;
                    n_emit  = '0;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    n_emit = r_emit + 1'b1;
                    if (r_emit == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_work) begin
            r_work[i_cmd.index[1:0]] <= i_cmd.value;
        end else if (do_round) begin
            r_work[0] <= d_w;
            r_work[1] <= b_w + rot;
            r_work[2] <= b_w;
            r_work[3] <= c_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_msg) begin
            r_msg[i_cmd.index] <= i_cmd.value;
        end
    end

    // Working words hold still while results are shown, so the payload is stable.
    assign o_out_valid           = (r_state == ST_EMIT);
    assign o_out_data.word_index = r_emit;
    assign o_out_data.word_value = r_work[r_emit];
    assign o_out_data.last       = (r_emit == 2'd3);

endmodule

// ===== hw/rtl/md5_round_core_unit.sv =====
`timescale 1ns / 1ps
// Path: with the queue empty and the back end idle, a load passes through the front register
// and a queue entry before it reaches the word stores; a run gives its four result transfers.
// Throughput: one load per cycle while the queue has room; a run leaves the queue, runs 64 rounds
// and gives four results, plus any output stall, before the back end takes its next command.
// Reset (synchronous, active low) clears the front register, the queue and the sequencer;
// the working and message words are not cleared and are undefined until loaded.

module md5_round_core_unit import md5rc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // The front end registers and decodes each input transfer, dropping items that
    // change nothing. A four-entry command queue decouples it from the back end, so
    // loads for the next chunk can arrive while the rounds of the current one run.
    t_cmd      front_cmd;
    logic      front_push;
    t_cmd      queue_cmd;
    logic      queue_pop;
    t_q_status queue_status;

    md5rc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (queue_status),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    md5rc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_cmd    (front_cmd),
        .i_pop    (queue_pop),
        .o_cmd    (queue_cmd),
        .o_status (queue_status)
    );

    // The back end holds the working and message words, runs the rounds in place
    // and presents the four words A to D as result transfers.
    md5rc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_q_status  (queue_status),
        .o_pop       (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import md5rc_pkg::*;

    // The operation code that the block must ignore entirely.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_ITEMS  = 80;       // the closing stretch runs with no idling
    localparam int SETTLE_CYCLES = 120;     // one run plus its four transfers, with margin
    localparam int CYCLE_LIMIT  = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    md5_round_core_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Standard MD5 per-round additive constants (the integer part of
    // abs(sin(i + 1)) scaled by 2^32), indexed by round number.
    logic [31:0] sine_addend [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts: four per quarter of the rounds, repeating every four rounds.
    logic [4:0] rotate_by [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // The directed rows. Every word is loaded before the first run, so no run
    // ever reads a word that was never written. Both ignored cases sit between
    // the loads and the first run, where any leak into the state would show up.
    t_in_item directed_items [26] = '{
        {OP_LOAD_WORK, 4'd0,  32'h00000000},
        {OP_LOAD_WORK, 4'd1,  32'hffffffff},
        {OP_LOAD_WORK, 4'd2,  32'h80000000},
        {OP_LOAD_WORK, 4'd3,  32'h7fffffff},
        {OP_LOAD_MSG,  4'd0,  32'h00000000},
        {OP_LOAD_MSG,  4'd1,  32'hffffffff},
        {OP_LOAD_MSG,  4'd2,  32'h80000000},
        {OP_LOAD_MSG,  4'd3,  32'h00000001},
        {OP_LOAD_MSG,  4'd4,  32'h7fffffff},
        {OP_LOAD_MSG,  4'd5,  32'hfffffffe},
        {OP_LOAD_MSG,  4'd6,  32'h00000080},
        {OP_LOAD_MSG,  4'd7,  32'h55555555},
        {OP_LOAD_MSG,  4'd8,  32'haaaaaaaa},
        {OP_LOAD_MSG,  4'd9,  32'h0f0f0f0f},
        {OP_LOAD_MSG,  4'd10, 32'hf0f0f0f0},
        {OP_LOAD_MSG,  4'd11, 32'h12345678},
        {OP_LOAD_MSG,  4'd12, 32'h9abcdef0},
        {OP_LOAD_MSG,  4'd13, 32'hdeadbeef},
        {OP_LOAD_MSG,  4'd14, 32'h00000000},
        {OP_LOAD_MSG,  4'd15, 32'hffffffff},
        {OP_LOAD_WORK, 4'd15, 32'hffffffff},
        {OP_UNUSED,    4'd15, 32'hffffffff},
        {OP_RUN,       4'd0,  32'h00000000},
        {OP_RUN,       4'd15, 32'hffffffff},
        {OP_LOAD_MSG,  4'd7,  32'h00000000},
        {OP_RUN,       4'd8,  32'h5a5a5a5a}
    };

    // The predictor's own copy of the block's state.
    logic [31:0] chunk_state [4];
    logic [31:0] chunk_msg   [16];

    // Words still to come out of the block, oldest first.
    t_out_item words_due [$];

    int  mismatch_count = 0;
    int  counted_items  = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  idle_on        = 1'b1;

    // Runs the 64 rounds over the predictor's state and queues the four words.
    task automatic compress_chunk();
        logic [31:0] a, b, c, d, mix, sum, held;
        logic [4:0]  amount;
        int          r;
        int          sel;
        t_out_item   word;
        a = chunk_state[0];
        b = chunk_state[1];
        c = chunk_state[2];
        d = chunk_state[3];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    mix = (b & c) | (~b & d);
                    sel = r;
                end
                1: begin
                    mix = (d & b) | (~d & c);
                    sel = 5 * r + 1;
                end
                2: begin
                    mix = b ^ c ^ d;
                    sel = 3 * r + 5;
                end
                default: begin
                    mix = c ^ (b | ~d);
                    sel = 7 * r;
                end
            endcase
            sel    = sel % 16;
            sum    = mix + a + sine_addend[r] + chunk_msg[sel];
            amount = rotate_by[(r / 16) * 4 + r % 4];
            held   = c;
            a      = d;
            d      = held;
            c      = b;
            b      = b + ((sum << amount) | (sum >> (32 - amount)));
        end
        chunk_state[0] = a;
        chunk_state[1] = b;
        chunk_state[2] = c;
        chunk_state[3] = d;
        for (r = 0; r < 4; r++) begin
            word.word_index = 2'(r);
            word.word_value = chunk_state[r];
            word.last       = (r == 3);
            words_due.push_back(word);
        end
    endtask

    // Applies one accepted item to the predictor's state.
    task automatic apply_item(input t_in_item item);
        case (item.operation)
            OP_LOAD_WORK: begin
                // Indexes beyond word D are dropped by the block.
                if (item.index < 4)
                    chunk_state[item.index[1:0]] = item.value;
            end
            OP_LOAD_MSG: begin
                chunk_msg[item.index] = item.value;
            end
            OP_RUN: begin
                compress_chunk();
            end
            default: begin
            end
        endcase
    endtask

    // Presents one item and holds it until the block takes it. An idle burst
    // may come first; valid is lowered only when such a burst is due, so it
    // never sees two assignments in one step.
    task automatic send_item(input t_in_item item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(item);
        counted_items++;
        @(negedge i_clk);
    endtask

    // Word values lean towards the extremes now and then.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly real loads with random content, with a few items the block drops.
    function automatic t_in_item pick_load();
        t_in_item item;
        int       roll;
        roll       = $urandom_range(0, 99);
        item.value = pick_value();
        if (roll < 60) begin
            item.operation = OP_LOAD_MSG;
            item.index     = 4'($urandom_range(0, 15));
        end else if (roll < 85) begin
            item.operation = OP_LOAD_WORK;
            item.index     = 4'($urandom_range(0, 3));
        end else if (roll < 93) begin
            item.operation = OP_LOAD_WORK;
            item.index     = 4'($urandom_range(4, 15));
        end else begin
            item.operation = OP_UNUSED;
            item.index     = 4'($urandom_range(0, 15));
        end
        return item;
    endfunction

    // The sink stalls in bursts while idling is allowed.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every output transfer is checked field by field against the oldest word due.
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (words_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, %s %0d value %08h last %0b",
                         $time, "got index", o_out_data.word_index,
                         o_out_data.word_value, o_out_data.last);
                mismatch_count++;
            end else begin
                due = words_due.pop_front();
                if (o_out_data.word_index !== due.word_index) begin
                    $display("%0t: word_index expected %0d, got %0d",
                             $time, due.word_index, o_out_data.word_index);
                    mismatch_count++;
                end
                if (o_out_data.word_value !== due.word_value) begin
                    $display("%0t: word_value (word %0d) expected %08h, got %08h",
                             $time, due.word_index, due.word_value, o_out_data.word_value);
                    mismatch_count++;
                end
                if (o_out_data.last !== due.last) begin
                    $display("%0t: last (word %0d) expected %0b, got %0b",
                             $time, due.word_index, due.last, o_out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int row;
        int loads;
        t_in_item item;

        for (row = 0; row < 4; row++)
            chunk_state[row] = '0;
        for (row = 0; row < 16; row++)
            chunk_msg[row] = '0;

        // Synchronous reset, active low, released on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_items[row])
            send_item(directed_items[row]);

        // Random chunks: a run of loads with random content, closed by a run.
        // Idling is switched on or off per chunk, and is off for the closing
        // stretch so that back-to-back transfers are also seen.
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (counted_items >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 4) != 0);
            loads = $urandom_range(0, 12);
            repeat (loads)
                send_item(pick_load());
            item.operation = OP_RUN;
            item.index     = 4'($urandom_range(0, 15));
            item.value     = $urandom;
            send_item(item);
        end
        idle_on    = 1'b0;
        i_in_valid <= 1'b0;

        // Drain what is still due, then give any stray transfer time to appear.
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
